// File: src/tvdt_pkg.sv
// Shared types and fixed-point widths for the two-view depth triangulation block.
// Used by every module under src; depends on nothing.
`default_nettype none
package tvdt_pkg;

  localparam int QW      = 16;   // quaternion, Q1.14
  localparam int TW      = 24;   // translation, Q12.12
  localparam int BW      = 20;   // bearings, Q4.16
  localparam int DMW     = 32;   // det_min
  localparam int CFG_W   = 32;   // config data port
  localparam int CFG_IW  = 3;    // config index port
  localparam int DEPTH_W = 24;   // depth result, Q12.12

  localparam int ROT_W  = 35;    // rotation entries, Q.28
  localparam int PR_W   = ROT_W + BW;
  localparam int RF_W   = 57;    // R*f row sums, Q.44
  localparam int A_W    = 28;    // rotated bearing, Q.16
  localparam int SUM_W  = 56;    // aa, ab, bb, a.t, b.t
  localparam int MUL_W  = SUM_W;
  localparam int PROD_W = 2 * MUL_W;
  localparam int DET_W  = PROD_W + 1;
  localparam int REM_W  = DET_W + 16;
  localparam int DIV_W  = DET_W + DEPTH_W;

  localparam int Q_DEPTH = 4;
  localparam int Q_AW    = $clog2(Q_DEPTH);

  localparam logic signed [ROT_W-1:0] ONE_Q28   = ROT_W'(64'sd268435456);
  localparam logic signed [RF_W-1:0]  ROUND_Q28 = RF_W'(64'sd134217728);

  typedef enum logic [CFG_IW-1:0] {
    CFG_QUAT_W  = 3'd0,
    CFG_QUAT_X  = 3'd1,
    CFG_QUAT_Y  = 3'd2,
    CFG_QUAT_Z  = 3'd3,
    CFG_TRANS_X = 3'd4,
    CFG_TRANS_Y = 3'd5,
    CFG_TRANS_Z = 3'd6,
    CFG_DET_MIN = 3'd7
  } cfg_idx_t;

  typedef struct packed {
    logic signed [QW-1:0] qw;
    logic signed [QW-1:0] qx;
    logic signed [QW-1:0] qy;
    logic signed [QW-1:0] qz;
    logic signed [TW-1:0] tx;
    logic signed [TW-1:0] ty;
    logic signed [TW-1:0] tz;
    logic [DMW-1:0]       det_min;
  } tvdt_cfg_t;

  // Word passed from the front pipeline to the divider.
  typedef struct packed {
    logic             ok;
    logic [DET_W-1:0] det;
    logic [REM_W-1:0] rem;
  } tvdt_job_t;

endpackage
`default_nettype wire

// File: src/tvdt_mul.sv
// Four-stage signed multiplier, split into four half-width partial products.
// Depends on tvdt_pkg.
`default_nettype none
module tvdt_mul (
  input  wire logic                              clk,
  input  wire logic                              en,
  input  wire logic signed [tvdt_pkg::MUL_W-1:0] a,
  input  wire logic signed [tvdt_pkg::MUL_W-1:0] b,
  output logic signed [tvdt_pkg::PROD_W-1:0]     p
);
  import tvdt_pkg::*;

  localparam int LO = MUL_W / 2;
  localparam int HI = MUL_W - LO;

  logic             neg1, neg2, neg3;
  logic [MUL_W-1:0] ma, mb;
  logic [2*LO-1:0]  pll;
  logic [LO+HI-1:0] plh, phl;
  logic [2*HI-1:0]  phh;
  logic [PROD_W-1:0] sum;

  always_ff @(posedge clk) begin
    if (en) begin
      neg1 <= a[MUL_W-1] ^ b[MUL_W-1];
      ma   <= a[MUL_W-1] ? $unsigned(-a) : $unsigned(a);
      mb   <= b[MUL_W-1] ? $unsigned(-b) : $unsigned(b);
      neg2 <= neg1;
      pll  <= ma[LO-1:0] * mb[LO-1:0];
      plh  <= (LO+HI)'(ma[LO-1:0]) * (LO+HI)'(mb[MUL_W-1:LO]);
      phl  <= (LO+HI)'(ma[MUL_W-1:LO]) * (LO+HI)'(mb[LO-1:0]);
      phh  <= ma[MUL_W-1:LO] * mb[MUL_W-1:LO];
      neg3 <= neg2;
      sum  <= (PROD_W'(phh) << (2 * LO)) + ((PROD_W'(plh) + PROD_W'(phl)) << LO)
              + PROD_W'(pll);
      p    <= neg3 ? -$signed(sum) : $signed(sum);
    end
  end

endmodule
`default_nettype wire

// File: src/tvdt_front.sv
// Front pipeline: rotates the reference bearing, forms the normal matrix,
// its determinant and the numerator, and classifies the word. Uses tvdt_pkg, tvdt_mul.
`default_nettype none
module tvdt_front (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire tvdt_pkg::tvdt_cfg_t              cfg,
  input  wire logic                             push,
  output logic                                  full,
  input  wire logic signed [tvdt_pkg::BW-1:0]   ref_x,
  input  wire logic signed [tvdt_pkg::BW-1:0]   ref_y,
  input  wire logic signed [tvdt_pkg::BW-1:0]   ref_z,
  input  wire logic signed [tvdt_pkg::BW-1:0]   cur_x,
  input  wire logic signed [tvdt_pkg::BW-1:0]   cur_y,
  input  wire logic signed [tvdt_pkg::BW-1:0]   cur_z,
  input  wire logic                             q_full,
  output logic                                  job_valid,
  output tvdt_pkg::tvdt_job_t                   job
);
  import tvdt_pkg::*;

  localparam int NF = 11;

  logic [NF-1:0] v;
  logic          en;

  logic signed [2*QW-1:0]  pxx, pyy, pzz, pxy, pxz, pyz, pwx, pwy, pwz;
  logic signed [ROT_W-1:0] rot [3][3];

  logic signed [BW-1:0]    f0 [3];
  logic signed [BW-1:0]    b0 [3], b1 [3], b2 [3];
  logic signed [PR_W-1:0]  pr [3][3];
  logic signed [RF_W-1:0]  s [3];
  logic signed [A_W-1:0]   a2 [3];
  logic signed [SUM_W-1:0] t [3];
  logic signed [SUM_W-1:0] paa [3], pab [3], pbb [3], pat [3], pbt [3];
  logic signed [SUM_W-1:0] aa4, ab4, bb4, at4, bt4;
  logic signed [PROD_W-1:0] m0, m1, m2, m3;
  logic signed [DET_W-1:0] det9, num9;
  logic [DET_W-1:0]        thr, mag9;

  assign full      = v[NF-1] & q_full;
  assign en        = !full;
  assign job_valid = v[NF-1];

  assign t[0] = SUM_W'(cfg.tx);
  assign t[1] = SUM_W'(cfg.ty);
  assign t[2] = SUM_W'(cfg.tz);

  // Rotation matrix is registered from the quaternion registers, so it follows them in the next cycle.
  always_comb begin
    pxx = cfg.qx * cfg.qx;
    pyy = cfg.qy * cfg.qy;
    pzz = cfg.qz * cfg.qz;
    pxy = cfg.qx * cfg.qy;
    pxz = cfg.qx * cfg.qz;
    pyz = cfg.qy * cfg.qz;
    pwx = cfg.qw * cfg.qx;
    pwy = cfg.qw * cfg.qy;
    pwz = cfg.qw * cfg.qz;
  end

  always_ff @(posedge clk) begin
    rot[0][0] <= ONE_Q28 - ((ROT_W'(pyy) + ROT_W'(pzz)) <<< 1);
    rot[0][1] <= (ROT_W'(pxy) - ROT_W'(pwz)) <<< 1;
    rot[0][2] <= (ROT_W'(pxz) + ROT_W'(pwy)) <<< 1;
    rot[1][0] <= (ROT_W'(pxy) + ROT_W'(pwz)) <<< 1;
    rot[1][1] <= ONE_Q28 - ((ROT_W'(pxx) + ROT_W'(pzz)) <<< 1);
    rot[1][2] <= (ROT_W'(pyz) - ROT_W'(pwx)) <<< 1;
    rot[2][0] <= (ROT_W'(pxz) - ROT_W'(pwy)) <<< 1;
    rot[2][1] <= (ROT_W'(pyz) + ROT_W'(pwx)) <<< 1;
    rot[2][2] <= ONE_Q28 - ((ROT_W'(pxx) + ROT_W'(pyy)) <<< 1);
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      s[i] = RF_W'(pr[i][0]) + RF_W'(pr[i][1]) + RF_W'(pr[i][2]) + ROUND_Q28;
    end
  end

  assign thr  = DET_W'({cfg.det_min, 32'h0});
  assign mag9 = num9[DET_W-1] ? $unsigned(-num9) : $unsigned(num9);

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (en) begin
      v <= {v[NF-2:0], push & !full};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f0[0] <= ref_x;
      f0[1] <= ref_y;
      f0[2] <= ref_z;
      b0[0] <= cur_x;
      b0[1] <= cur_y;
      b0[2] <= cur_z;
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          pr[i][j] <= PR_W'(rot[i][j]) * PR_W'(f0[j]);
        end
        b1[i]  <= b0[i];
        a2[i]  <= A_W'(s[i] >>> 28);
        b2[i]  <= b1[i];
        paa[i] <= SUM_W'(a2[i]) * SUM_W'(a2[i]);
        pab[i] <= SUM_W'(a2[i]) * SUM_W'(b2[i]);
        pbb[i] <= SUM_W'(b2[i]) * SUM_W'(b2[i]);
        pat[i] <= SUM_W'(a2[i]) * t[i];
        pbt[i] <= SUM_W'(b2[i]) * t[i];
      end
      aa4  <= paa[0] + paa[1] + paa[2];
      ab4  <= pab[0] + pab[1] + pab[2];
      bb4  <= pbb[0] + pbb[1] + pbb[2];
      at4  <= pat[0] + pat[1] + pat[2];
      bt4  <= pbt[0] + pbt[1] + pbt[2];
      det9 <= DET_W'(m0) - DET_W'(m1);
      num9 <= DET_W'(m2) - DET_W'(m3);
      // Reject a singular or ill-conditioned pair.
      job.ok  <= !det9[DET_W-1] && (det9 != '0) && ($unsigned(det9) >= thr);
      job.det <= $unsigned(det9);
      job.rem <= REM_W'(mag9) << 16;
    end
  end

  tvdt_mul u_mul_det0 (.clk(clk), .en(en), .a(aa4), .b(bb4), .p(m0));
  tvdt_mul u_mul_det1 (.clk(clk), .en(en), .a(ab4), .b(ab4), .p(m1));
  tvdt_mul u_mul_num0 (.clk(clk), .en(en), .a(bb4), .b(at4), .p(m2));
  tvdt_mul u_mul_num1 (.clk(clk), .en(en), .a(ab4), .b(bt4), .p(m3));

endmodule
`default_nettype wire

// File: src/tvdt_queue.sv
// Short queue of classified words between the front pipeline and the divider.
// Depends on tvdt_pkg.
`default_nettype none
module tvdt_queue (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                push,
  input  wire tvdt_pkg::tvdt_job_t din,
  input  wire logic                pop,
  output tvdt_pkg::tvdt_job_t      dout,
  output logic                     empty,
  output logic                     full
);
  import tvdt_pkg::*;

  tvdt_job_t        mem [Q_DEPTH];
  logic [Q_AW-1:0]  wr_ptr, rd_ptr;
  logic [Q_AW:0]    count;

  assign empty = (count == '0);
  assign full  = (count == (Q_AW+1)'(Q_DEPTH));
  assign dout  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count + (Q_AW+1)'(push) - (Q_AW+1)'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= din;
    end
  end

endmodule
`default_nettype wire

// File: src/tvdt_back.sv
// Back pipeline: restoring divider, a load stage then one quotient bit per
// stage, with saturation and an output register. Depends on tvdt_pkg.
`default_nettype none
module tvdt_back (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire tvdt_pkg::tvdt_job_t        job,
  input  wire logic                       q_empty,
  output logic                            q_pop,
  output logic                            empty,
  input  wire logic                       pop,
  output logic [tvdt_pkg::DEPTH_W-1:0]    depth_out,
  output logic                            depth_valid
);
  import tvdt_pkg::*;

  localparam int NS = DEPTH_W + 1;

  logic                en;
  logic                out_v;
  logic [NS-1:0]       v;
  logic                ok   [NS];
  logic                ovf  [NS];
  logic [DET_W-1:0]    det  [NS];
  logic [REM_W-1:0]    rem  [NS];
  logic [DEPTH_W-1:0]  quo  [NS];
  logic [DIV_W-1:0]    dsh  [NS];
  logic                ge   [NS];

  assign en    = !out_v || pop;
  assign q_pop = en && !q_empty;
  assign empty = !out_v;

  // Stage k settles quotient bit DEPTH_W-k.
  always_comb begin
    dsh[0] = '0;
    ge[0]  = 1'b0;
    for (int k = 1; k < NS; k++) begin
      dsh[k] = DIV_W'(det[k-1]) << (DEPTH_W - k);
      ge[k]  = dsh[k] <= DIV_W'(rem[k-1]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v     <= '0;
      out_v <= 1'b0;
    end else if (en) begin
      v     <= {v[NS-2:0], q_pop};
      out_v <= v[NS-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ok[0]  <= job.ok;
      det[0] <= job.det;
      rem[0] <= job.rem;
      quo[0] <= '0;
      ovf[0] <= (DIV_W'(job.det) << DEPTH_W) <= DIV_W'(job.rem);
      for (int k = 1; k < NS; k++) begin
        ok[k]  <= ok[k-1];
        ovf[k] <= ovf[k-1];
        det[k] <= det[k-1];
        rem[k] <= ge[k] ? REM_W'(DIV_W'(rem[k-1]) - dsh[k]) : rem[k-1];
        quo[k] <= quo[k-1] | (DEPTH_W'(ge[k]) << (DEPTH_W - k));
      end
      depth_valid <= ok[NS-1];
      priority if (!ok[NS-1]) begin
        depth_out <= '0;
      end else if (ovf[NS-1]) begin
        depth_out <= '1;
      end else begin
        depth_out <= quo[NS-1];
      end
    end
  end

endmodule
`default_nettype wire

// File: src/two_view_depth_triangulation_top.sv
// Top level of the two-view depth triangulation block: config registers,
// front pipeline, word queue and divider. Uses tvdt_pkg and the tvdt_* modules.
//
//   channel  | handshake             | payload
//   ---------+-----------------------+--------------------------------------
//   config   | cfg_we                | cfg_index[2:0], cfg_data[31:0]
//   input    | push / full           | ref_x/y/z, cur_x/y/z (20b signed)
//   result   | pop / empty           | depth_out[23:0], depth_valid
//
// One word is accepted every cycle while full is low; a word passes 11 front
// stages, the queue, 25 divider stages (a load stage, then one quotient bit per
// stage) and the output register. The rotation matrix is registered. Reset is
// synchronous, clears the pipelines and queue and resets the config registers.
// A held result stalls the divider; the 4-word queue then fills and full rises.
`default_nettype none
module two_view_depth_triangulation_top (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              cfg_we,
  input  wire logic [tvdt_pkg::CFG_IW-1:0]       cfg_index,
  input  wire logic [tvdt_pkg::CFG_W-1:0]        cfg_data,
  input  wire logic                              push,
  output logic                                   full,
  input  wire logic signed [tvdt_pkg::BW-1:0]    ref_x,
  input  wire logic signed [tvdt_pkg::BW-1:0]    ref_y,
  input  wire logic signed [tvdt_pkg::BW-1:0]    ref_z,
  input  wire logic signed [tvdt_pkg::BW-1:0]    cur_x,
  input  wire logic signed [tvdt_pkg::BW-1:0]    cur_y,
  input  wire logic signed [tvdt_pkg::BW-1:0]    cur_z,
  output logic                                   empty,
  input  wire logic                              pop,
  output logic [tvdt_pkg::DEPTH_W-1:0]           depth_out,
  output logic                                   depth_valid
);
  import tvdt_pkg::*;

  tvdt_cfg_t cfg;
  tvdt_job_t job_f, job_q;
  logic      job_valid, q_full, q_empty, q_pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.qw      <= QW'(16'sd16384);
      cfg.qx      <= '0;
      cfg.qy      <= '0;
      cfg.qz      <= '0;
      cfg.tx      <= '0;
      cfg.ty      <= '0;
      cfg.tz      <= '0;
      cfg.det_min <= DMW'(32'd4295);
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_QUAT_W:  cfg.qw      <= cfg_data[QW-1:0];
        CFG_QUAT_X:  cfg.qx      <= cfg_data[QW-1:0];
        CFG_QUAT_Y:  cfg.qy      <= cfg_data[QW-1:0];
        CFG_QUAT_Z:  cfg.qz      <= cfg_data[QW-1:0];
        CFG_TRANS_X: cfg.tx      <= cfg_data[TW-1:0];
        CFG_TRANS_Y: cfg.ty      <= cfg_data[TW-1:0];
        CFG_TRANS_Z: cfg.tz      <= cfg_data[TW-1:0];
        CFG_DET_MIN: cfg.det_min <= cfg_data[DMW-1:0];
        default: ;
      endcase
    end
  end

  tvdt_front u_front (
    .clk(clk), .rst(rst), .cfg(cfg), .push(push), .full(full),
    .ref_x(ref_x), .ref_y(ref_y), .ref_z(ref_z),
    .cur_x(cur_x), .cur_y(cur_y), .cur_z(cur_z),
    .q_full(q_full), .job_valid(job_valid), .job(job_f)
  );

  tvdt_queue u_queue (
    .clk(clk), .rst(rst), .push(job_valid & !q_full), .din(job_f),
    .pop(q_pop), .dout(job_q), .empty(q_empty), .full(q_full)
  );

  tvdt_back u_back (
    .clk(clk), .rst(rst), .job(job_q), .q_empty(q_empty), .q_pop(q_pop),
    .empty(empty), .pop(pop), .depth_out(depth_out), .depth_valid(depth_valid)
  );

endmodule
`default_nettype wire

// File: tb/sv/tb_two_view_depth_triangulation_top.sv
// Testbench for two_view_depth_triangulation_top: a directed table, then random
// correspondences under several settings, checked against a predictor. Uses tvdt_pkg.
`timescale 1ns / 1ps
module tb_two_view_depth_triangulation_top;
  import tvdt_pkg::*;

  typedef struct {
    logic signed [BW-1:0] rx, ry, rz, cx, cy, cz;
    bit                   has_exp;
    logic [DEPTH_W-1:0]   exp_depth;
    logic                 exp_valid;
  } bearing_row_t;

  typedef struct {
    logic [DEPTH_W-1:0] depth;
    logic               valid;
  } depth_word_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [CFG_IW-1:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_data = '0;
  logic push = 1'b0;
  logic full, empty, depth_valid;
  logic pop = 1'b0;
  logic signed [BW-1:0] ref_x = '0, ref_y = '0, ref_z = '0;
  logic signed [BW-1:0] cur_x = '0, cur_y = '0, cur_z = '0;
  logic [DEPTH_W-1:0] depth_out;

  two_view_depth_triangulation_top dut (.*);

  initial begin
    forever #1 clk = ~clk;
  end

  // Predictor copy of the pose registers.
  logic signed [15:0] pw = 16'sd16384, px = '0, py = '0, pz = '0;
  logic signed [23:0] ptx = '0, pty = '0, ptz = '0;
  logic [31:0] pdet_min = 32'd4295;

  depth_word_t pending_depths[$];
  int failures = 0;
  int idle_cycles = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_off = 0;

  function automatic depth_word_t triangulate_depth(bearing_row_t r);
    logic signed [127:0] rot[3][3];
    logic signed [127:0] f[3], b[3], a[3], t[3], s;
    logic signed [127:0] aa, ab, bb, at, bt, det, num;
    logic [127:0] mag, thr, quo;
    depth_word_t o;
    logic signed [127:0] w, x, y, z;
    w = pw; x = px; y = py; z = pz;
    f[0] = r.rx; f[1] = r.ry; f[2] = r.rz;
    b[0] = r.cx; b[1] = r.cy; b[2] = r.cz;
    t[0] = ptx; t[1] = pty; t[2] = ptz;
    rot[0][0] = (128'sd1 <<< 28) - 2 * (y * y + z * z);
    rot[0][1] = 2 * (x * y - w * z);
    rot[0][2] = 2 * (x * z + w * y);
    rot[1][0] = 2 * (x * y + w * z);
    rot[1][1] = (128'sd1 <<< 28) - 2 * (x * x + z * z);
    rot[1][2] = 2 * (y * z - w * x);
    rot[2][0] = 2 * (x * z - w * y);
    rot[2][1] = 2 * (y * z + w * x);
    rot[2][2] = (128'sd1 <<< 28) - 2 * (x * x + y * y);
    aa = 0; ab = 0; bb = 0; at = 0; bt = 0;
    for (int i = 0; i < 3; i++) begin
      s = rot[i][0] * f[0] + rot[i][1] * f[1] + rot[i][2] * f[2];
      a[i] = (s + (128'sd1 <<< 27)) >>> 28;
    end
    for (int i = 0; i < 3; i++) begin
      aa += a[i] * a[i]; ab += a[i] * b[i]; bb += b[i] * b[i];
      at += a[i] * t[i]; bt += b[i] * t[i];
    end
    det = aa * bb - ab * ab;
    thr = {96'd0, pdet_min} << 32;
    o.depth = '0;
    o.valid = 1'b0;
    if (det <= 0 || $unsigned(det) < thr) return o;
    num = bb * at - ab * bt;
    mag = num < 0 ? -num : num;
    quo = (mag << 16) / $unsigned(det);
    o.depth = quo > 128'hFFFFFF ? 24'hFFFFFF : quo[23:0];
    o.valid = 1'b1;
    return o;
  endfunction

  task automatic write_pose_reg(cfg_idx_t idx, logic [31:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      CFG_QUAT_W: pw = val[15:0];
      CFG_QUAT_X: px = val[15:0];
      CFG_QUAT_Y: py = val[15:0];
      CFG_QUAT_Z: pz = val[15:0];
      CFG_TRANS_X: ptx = val[23:0];
      CFG_TRANS_Y: pty = val[23:0];
      CFG_TRANS_Z: ptz = val[23:0];
      default: pdet_min = val;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_pose(int qw, int qx, int qy, int qz, int tx, int ty, int tz,
                          logic [31:0] dm);
    write_pose_reg(CFG_QUAT_W, qw);
    write_pose_reg(CFG_QUAT_X, qx);
    write_pose_reg(CFG_QUAT_Y, qy);
    write_pose_reg(CFG_QUAT_Z, qz);
    write_pose_reg(CFG_TRANS_X, tx);
    write_pose_reg(CFG_TRANS_Y, ty);
    write_pose_reg(CFG_TRANS_Z, tz);
    write_pose_reg(CFG_DET_MIN, dm);
    repeat (4) @(negedge clk);
  endtask

  // Push one correspondence; called at a falling edge, returns at one.
  // Push stays high on return so words can follow back to back.
  task automatic send_bearings(bearing_row_t r);
    depth_word_t e;
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(negedge clk);
    end
    push <= 1'b1;
    ref_x <= r.rx; ref_y <= r.ry; ref_z <= r.rz;
    cur_x <= r.cx; cur_y <= r.cy; cur_z <= r.cz;
    do @(posedge clk); while (full);
    e = triangulate_depth(r);
    if (r.has_exp && e.depth != r.exp_depth) begin
      $error("table depth_out expected %0d predictor %0d", r.exp_depth, e.depth);
      failures++;
    end
    if (r.has_exp && e.valid != r.exp_valid) begin
      $error("table depth_valid expected %0d predictor %0d", r.exp_valid, e.valid);
      failures++;
    end
    if (r.has_exp) begin
      e.depth = r.exp_depth;
      e.valid = r.exp_valid;
    end
    pending_depths.push_back(e);
    @(negedge clk);
  endtask

  function automatic logic signed [BW-1:0] rand_comp(int mode);
    case (mode)
      0: return $urandom_range(1 << 16) - (1 << 15);
      1: return BW'($urandom);
      default: return $urandom_range(2) == 0 ? -20'sd524288 :
                      ($urandom_range(1) ? 20'sd524287 : 20'sd0);
    endcase
  endfunction

  function automatic bearing_row_t rand_row();
    bearing_row_t r;
    int m;
    m = $urandom_range(9) < 7 ? 0 : ($urandom_range(3) == 0 ? 2 : 1);
    r.rx = rand_comp(m); r.ry = rand_comp(m); r.rz = rand_comp(m);
    r.cx = rand_comp(m); r.cy = rand_comp(m); r.cz = rand_comp(m);
    // Keep most bearings forward-looking so depths come out valid.
    if (m == 0) begin
      r.rz = 20'sd65536 + $urandom_range(4096);
      r.cz = 20'sd65536 + $urandom_range(4096);
    end
    r.has_exp = 0;
    return r;
  endfunction

  // Result side: stall per percentage, long hold-off on request.
  always @(negedge clk) begin
    if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      pop <= 1'b0;
    end else begin
      pop <= !(recv_stall_pct > 0 && $urandom_range(99) < recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    depth_word_t e;
    if (!rst && pop && !empty) begin
      if (pending_depths.size() == 0) begin
        $error("result word with nothing expected");
        failures++;
      end else begin
        e = pending_depths.pop_front();
        if (depth_out !== e.depth) begin
          $error("depth_out expected %0d actual %0d", e.depth, depth_out);
          failures++;
        end
        if (depth_valid !== e.valid) begin
          $error("depth_valid expected %0d actual %0d", e.valid, depth_valid);
          failures++;
        end
      end
    end
  end

  // Watchdog: cycles without any accepted word.
  always @(posedge clk) begin
    if ((push && !full) || (pop && !empty) || rst || cfg_we) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 20000) begin
      $display("two_view_depth_triangulation_top test failed");
      $finish;
    end
  end

  task automatic drain();
    push <= 1'b0;
    while (pending_depths.size() != 0) @(negedge clk);
    repeat (60) @(negedge clk);
  endtask

  bearing_row_t dir_rows[$];

  function automatic bearing_row_t mk(int rx, int ry, int rz, int cx, int cy, int cz);
    bearing_row_t r;
    r.rx = rx; r.ry = ry; r.rz = rz; r.cx = cx; r.cy = cy; r.cz = cz;
    r.has_exp = 0;
    return r;
  endfunction

  initial begin
    bearing_row_t r;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed table under reset pose: identity, zero translation.
    r = mk(0, 0, 65536, 0, 0, 65536);     // parallel rays: det 0
    r.has_exp = 1; r.exp_depth = 0; r.exp_valid = 0; dir_rows.push_back(r);
    r = mk(0, 0, 0, 0, 0, 0);             // zero bearings
    r.has_exp = 1; r.exp_depth = 0; r.exp_valid = 0; dir_rows.push_back(r);
    r = mk(0, 0, 65536, 65536, 0, 65536); // zero translation gives depth 0
    r.has_exp = 1; r.exp_depth = 0; r.exp_valid = 1; dir_rows.push_back(r);
    dir_rows.push_back(mk(-524288, -524288, -524288, 524287, 524287, 524287));
    dir_rows.push_back(mk(524287, -524288, 524287, -524288, 524287, -524288));
    dir_rows.push_back(mk(1, 0, 0, 0, 1, 0));
    foreach (dir_rows[i]) send_bearings(dir_rows[i]);
    drain();

    // Translation set, identity rotation; tiny crossing angle saturates depth.
    set_pose(16384, 0, 0, 0, 8388607, -8388608, 4096, 0);
    dir_rows.delete();
    dir_rows.push_back(mk(0, 0, 65536, 65536, 0, 65536));
    dir_rows.push_back(mk(0, 0, 65536, 1, 0, 65536));
    dir_rows.push_back(mk(0, 0, 65536, 0, 0, 65536));   // det 0 with det_min 0
    dir_rows.push_back(mk(-524288, 524287, 1, 1, -524288, 524287));
    foreach (dir_rows[i]) send_bearings(dir_rows[i]);
    drain();
    set_pose(-16384, 16384, -16384, 16384, 4096, 0, 0, 32'hFFFFFFFF);
    send_bearings(mk(0, 0, 65536, 65536, 0, 65536));
    send_bearings(mk(524287, 0, 0, 0, 524287, 0));
    drain();
    set_pose(32767, -32768, 0, 65535, 0, 0, 0, 0);
    send_bearings(mk(65536, 65536, 65536, -65536, 0, 65536));
    drain();

    // Random phases over several poses and idling patterns.
    for (int ph = 0; ph < 8; ph++) begin
      case (ph % 4)
        0: begin send_idle_pct = 0; recv_stall_pct = 0; end
        1: begin send_idle_pct = 48; recv_stall_pct = 0; end
        2: begin send_idle_pct = 0; recv_stall_pct = 48; end
        default: begin send_idle_pct = 14; recv_stall_pct = 14; end
      endcase
      if (ph == 7) set_pose($urandom, $urandom, $urandom, $urandom,
                            $urandom, $urandom, $urandom, $urandom);
      else set_pose(16384 - $urandom_range(2000), $urandom_range(4000) - 2000,
                    $urandom_range(4000) - 2000, $urandom_range(4000) - 2000,
                    $urandom_range(1 << 16) - (1 << 15), $urandom_range(8192) - 4096,
                    $urandom_range(8192) - 4096, $urandom_range(ph * 3000));
      if (ph == 2) hold_off = 300;
      for (int n = 0; n < 210; n++) send_bearings(rand_row());
      drain();
    end

    if (failures == 0)
      $display("two_view_depth_triangulation_top test passed");
    else
      $display("two_view_depth_triangulation_top test failed");
    $finish;
  end
endmodule
